>>> rtl/core/b64enc_pkg.sv
`default_nettype none

package b64enc_pkg;

   localparam int unsigned CHAR_WIDTH = 7;
   localparam int unsigned JOB_CHARS  = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 7'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH = 7'h2F;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PAD   = 7'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] code_char;
      logic                  last_char;
   } rsp_payload_type;

   // One request turned into the characters that it yields.
   typedef struct packed {
      logic [JOB_CHARS-1:0][CHAR_WIDTH-1:0] chars;
      logic [1:0]                           final_index;
      logic                                 mark_last;
   } job_type;

   function automatic logic [CHAR_WIDTH-1:0] sextet_char(input logic [5:0] v);
      logic [CHAR_WIDTH-1:0] wide;
      logic [CHAR_WIDTH-1:0] res;
      wide = {1'b0, v};
      if (v < 6'd26) begin
         res = wide + 7'd65;
      end else if (v < 6'd52) begin
         res = wide + 7'd71;
      end else if (v < 6'd62) begin
         res = wide - 7'd4;
      end else if (v == 6'd62) begin
         res = CHAR_PLUS;
      end else begin
         res = CHAR_SLASH;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/base64_stream_encoder_unit.sv
`default_nettype none

// Streaming base64 encoder, standard alphabet with '=' padding. Each request
// carries one message byte and an end-of-message flag; each response carries
// one ASCII character, and the final character of a message is flagged. A byte
// yields one or two characters mid-message, and the last byte of a message
// also flushes and pads its group, giving two to four characters in all. The
// back end hands out one character per cycle from its output register while
// rsp_ready is high, and three bytes yield four characters mid-message. The
// front end encodes a byte in the cycle that it is accepted and keeps
// accepting while the job queue of QUEUE_DEPTH entries has room.
module base64_stream_encoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire b64enc_pkg::req_payload_type req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output b64enc_pkg::rsp_payload_type      rsp_payload
);
   import b64enc_pkg::*;

   job_type push_job;
   job_type pop_job;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;

   b64enc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   b64enc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_job     (pop_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> rtl/core/b64enc_front.sv
`default_nettype none

module b64enc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire b64enc_pkg::req_payload_type req_payload,
   input  wire logic                      queue_full,
   output logic                           push,
   output b64enc_pkg::job_type            push_job
);
   import b64enc_pkg::*;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] b;
   logic       eom;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign b         = req_payload.data_byte;
   assign eom       = req_payload.end_of_message;

   always_comb begin
      push_job.chars       = {JOB_CHARS{CHAR_PAD}};
      push_job.final_index = 2'd0;
      push_job.mark_last   = eom;
      phase_in             = PHASE_FIRST;
      left_in              = 4'd0;
      case (phase_ff)
         PHASE_SECOND: begin
            push_job.chars[0] = sextet_char({left_ff[1:0], b[7:4]});
            if (eom) begin
               push_job.chars[1]    = sextet_char({b[3:0], 2'b00});
               push_job.final_index = 2'd2;
            end else begin
               left_in  = b[3:0];
               phase_in = PHASE_THIRD;
            end
         end
         PHASE_THIRD: begin
            push_job.chars[0]    = sextet_char({left_ff, b[7:6]});
            push_job.chars[1]    = sextet_char(b[5:0]);
            push_job.final_index = 2'd1;
         end
         default: begin
            push_job.chars[0] = sextet_char(b[7:2]);
            if (eom) begin
               push_job.chars[1]    = sextet_char({b[1:0], 4'b0000});
               push_job.final_index = 2'd3;
            end else begin
               left_in  = {2'b00, b[1:0]};
               phase_in = PHASE_SECOND;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/b64enc_queue.sv
`default_nettype none

module b64enc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire b64enc_pkg::job_type push_job,
   output logic                     full,
   input  wire logic                pop,
   output b64enc_pkg::job_type      pop_job,
   output logic                     empty
);
   import b64enc_pkg::*;

   // DEPTH must be at least two.
   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   job_type         entries [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/b64enc_back.sv
`default_nettype none

module b64enc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire b64enc_pkg::job_type pop_job,
   input  wire logic                queue_empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output b64enc_pkg::rsp_payload_type rsp_payload
);
   import b64enc_pkg::*;

   job_type    job_ff;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_final;
   logic       done;

   assign at_final  = (idx_ff == job_ff.final_index);
   assign done      = busy_ff && rsp_ready && at_final;
   // A new request is loaded as the previous one hands over its final character.
   assign pop       = !queue_empty && (!busy_ff || done);

   assign rsp_valid             = busy_ff;
   assign rsp_payload.code_char = job_ff.chars[idx_ff];
   assign rsp_payload.last_char = job_ff.mark_last && at_final;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (done) begin
         busy_in = 1'b0;
         idx_in  = 2'd0;
      end else if (busy_ff && rsp_ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= pop_job;
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/base64_stream_encoder_unit_test.sv
`timescale 1ns / 100ps

module base64_stream_encoder_unit_test;
   import b64enc_pkg::*;

   localparam int unsigned RANDOM_BYTES = 480;
   localparam int unsigned MAX_WAIT     = 14;
   localparam int unsigned DRAIN_CYCLES = 20;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   localparam logic [0:63][7:0] DIGITS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   req_payload_type pending_bytes[$];
   rsp_payload_type expected_chars[$];

   // Encoder state as the predictor sees it.
   logic [1:0]  enc_phase = PHASE_FIRST;
   logic [3:0]  enc_carry = 4'd0;

   int unsigned fail_count     = 0;
   int unsigned accepted_count = 0;
   int unsigned req_wait       = 0;
   int unsigned rsp_wait       = 0;
   bit          req_quiet      = 1'b0;
   bit          rsp_quiet      = 1'b0;

   base64_stream_encoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int unsigned draw_wait(input bit quiet);
      if (quiet || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic void push_char(input logic [6:0] ch, input logic last);
      rsp_payload_type entry;
      entry.code_char = ch;
      entry.last_char = last;
      expected_chars.push_back(entry);
   endfunction

   function automatic logic [6:0] digit_of(input logic [5:0] v);
      return DIGITS[v][6:0];
   endfunction

   // Works out the characters that one request yields and advances the state.
   function automatic void encode_byte(input req_payload_type item);
      logic [7:0] b;
      logic       eom;
      b   = item.data_byte;
      eom = item.end_of_message;
      case (enc_phase)
         PHASE_SECOND: begin
            push_char(digit_of({enc_carry[1:0], b[7:4]}), 1'b0);
            if (eom) begin
               push_char(digit_of({b[3:0], 2'b00}), 1'b0);
               push_char(CHAR_PAD, 1'b1);
               enc_phase = PHASE_FIRST;
               enc_carry = 4'd0;
            end else begin
               enc_carry = b[3:0];
               enc_phase = PHASE_THIRD;
            end
         end
         PHASE_THIRD: begin
            push_char(digit_of({enc_carry, b[7:6]}), 1'b0);
            push_char(digit_of(b[5:0]), eom);
            enc_phase = PHASE_FIRST;
            enc_carry = 4'd0;
         end
         default: begin
            push_char(digit_of(b[7:2]), 1'b0);
            if (eom) begin
               push_char(digit_of({b[1:0], 4'b0000}), 1'b0);
               push_char(CHAR_PAD, 1'b0);
               push_char(CHAR_PAD, 1'b1);
               enc_phase = PHASE_FIRST;
               enc_carry = 4'd0;
            end else begin
               enc_carry = {2'b00, b[1:0]};
               enc_phase = PHASE_SECOND;
            end
         end
      endcase
   endfunction

   task automatic add_byte(input logic [7:0] b, input logic eom);
      req_payload_type item;
      item.data_byte      = b;
      item.end_of_message = eom;
      pending_bytes.push_back(item);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            encode_byte(req_payload);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if ($urandom_range(0, 39) == 0) begin
               req_quiet = !req_quiet;
            end
            if (req_wait != 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_payload <= pending_bytes.pop_front();
               req_valid   <= 1'b1;
               req_wait    = draw_wait(req_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character %h last %b",
                  rsp_payload.code_char, rsp_payload.last_char));
            end else begin
               if (rsp_payload.code_char !== expected_chars[0].code_char) begin
                  report_mismatch($sformatf("code_char %h, wanted %h",
                     rsp_payload.code_char, expected_chars[0].code_char));
               end
               if (rsp_payload.last_char !== expected_chars[0].last_char) begin
                  report_mismatch($sformatf("last_char %b, wanted %b",
                     rsp_payload.last_char, expected_chars[0].last_char));
               end
               void'(expected_chars.pop_front());
            end
            if ($urandom_range(0, 39) == 0) begin
               rsp_quiet = !rsp_quiet;
            end
            rsp_wait = draw_wait(rsp_quiet);
         end
         if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned random_count;
      int unsigned msg_len;
      int unsigned i;
      int unsigned total_count;
      random_count = 0;

      // Single bytes at both extremes, so both pad characters are produced.
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      // Two bytes: one pad.
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b1);
      // Full groups, the second giving the two top digits of the alphabet.
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'hF8, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hBF, 1'b1);
      // Longer messages ending at each phase of the group.
      add_byte(8'h66, 1'b0);
      add_byte(8'h6F, 1'b0);
      add_byte(8'h6F, 1'b0);
      add_byte(8'h62, 1'b1);
      add_byte(8'h66, 1'b0);
      add_byte(8'h6F, 1'b0);
      add_byte(8'h6F, 1'b0);
      add_byte(8'h62, 1'b0);
      add_byte(8'h61, 1'b1);
      add_byte(8'h80, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(8'h01, 1'b1);

      while (random_count < RANDOM_BYTES) begin
         if ($urandom_range(0, 7) == 0) begin
            msg_len = $urandom_range(13, 40);
         end else begin
            msg_len = $urandom_range(1, 12);
         end
         for (i = 0; i < msg_len; i++) begin
            add_byte(pick_byte(), i == msg_len - 1);
         end
         random_count += msg_len;
      end
      total_count = pending_bytes.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Every request must have been accepted before the drain starts.
      while (accepted_count < total_count) begin
         @(posedge clock);
      end
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("base64_stream_encoder_unit: match");
      end else begin
         $display("base64_stream_encoder_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("base64_stream_encoder_unit: mismatch");
      $finish;
   end

endmodule

>>> base64_stream_encoder_unit.f
rtl/core/b64enc_pkg.sv
rtl/core/b64enc_front.sv
rtl/core/b64enc_queue.sv
rtl/core/b64enc_back.sv
rtl/core/base64_stream_encoder_unit.sv
tb/sv/base64_stream_encoder_unit_test.sv
